[hw/rtl/setq_pkg.sv]
// Package for the sorted expiry timer queue: sizes, command and status codes, FSM states, word layouts.
// No dependencies.
`default_nettype none
package setq_pkg;
	localparam int HandleW = 10;
	localparam int TimeW   = 32;
	localparam int MaxResults = 32;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_ADJUST = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_DUP       = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND_RD,
		S_FIND_CHK,
		S_REM_RD,
		S_REM_WR,
		S_INS_RD,
		S_INS_CHK,
		S_INS_WR,
		S_TICK_RD,
		S_TICK_CHK,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [9:0]  handle;
		logic [31:0] expire_time;
		logic [31:0] now;
	} in_word_t;

	typedef struct packed {
		logic [9:0] expired_handle;
		logic       fired;
		logic [1:0] status;
		logic       last;
	} out_word_t;
endpackage
`default_nettype wire

[hw/rtl/setq_if.sv]
// Valid/ready channel interface carrying one word of type T.
// Depends on setq_pkg for the word types.
`default_nettype none
interface setq_if #(parameter type T = setq_pkg::in_word_t) (input wire logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/sorted_expiry_timer_queue.sv]
// Top level of the sorted expiry timer queue.
// Depends on setq_pkg and setq_if.
//
// Usage: commands enter on in_ch (cmd, handle, expire_time, now); results leave on
// out_ch (expired_handle, fired, status, last). Both are valid/ready channels; a word
// moves when valid and ready are high at a rising clk edge.
// Timers sit in a sorted array held in one synchronous memory (one read, one
// write port, registered read). Every command is worked by a sequencer that
// walks the memory one entry at a time:
//   add:    linear scan for duplicates, then search for the insertion point
//           from the tail, shifting entries up.
//   adjust/delete: scan for the handle, shift the tail down, then for adjust
//           re-insert as in add.
//   tick:   pops from the front; each popped entry costs a read, a compare and a
//           shift down of the rest.
// One command is worked at a time; in_ch.ready is high only when the sequencer
// is idle. Each result is held in an output register; when the receiver stalls,
// the sequencer waits in place with the result held. Reset (arst_n low) clears
// the occupancy count and the sequencer; memory contents are not cleared, as
// only positions below the count are ever used.
`default_nettype none
module sorted_expiry_timer_queue #(
	parameter int ENTRIES = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	setq_if.sink      in_ch,
	setq_if.source    out_ch
);
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int RW = $clog2(setq_pkg::MaxResults + 1);

	typedef struct packed {
		logic [31:0] expiry;
		logic [9:0]  handle;
	} slot_t;

	slot_t mem [ENTRIES];
	slot_t rd_data_q;
	logic  [AW-1:0] rd_addr;
	logic           wr_en;
	logic  [AW-1:0] wr_addr;
	slot_t          wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	setq_pkg::state_t state_q, state_d;
	logic [CW-1:0]  count_q, count_d;
	logic [CW-1:0]  idx_q, idx_d;       // walking position
	logic [RW-1:0]  npop_q, npop_d;     // pops in this tick
	setq_pkg::in_word_t cmd_q, cmd_d;
	setq_pkg::out_word_t res_q, res_d;
	logic           res_valid_q, res_valid_d;
	setq_pkg::state_t after_q, after_d; // state to resume after emit
	slot_t          popped_q, popped_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= setq_pkg::S_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		npop_q   <= npop_d;
		cmd_q    <= cmd_d;
		res_q    <= res_d;
		after_q  <= after_d;
		popped_q <= popped_d;
	end

	assign in_ch.ready  = (state_q == setq_pkg::S_IDLE);
	assign out_ch.valid = res_valid_q;
	assign out_ch.data  = res_q;

	function automatic setq_pkg::out_word_t mk_res(logic [9:0] h, logic f,
			setq_pkg::status_t s, logic l);
		setq_pkg::out_word_t r;
		r.expired_handle = h;
		r.fired          = f;
		r.status         = s;
		r.last           = l;
		return r;
	endfunction

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		idx_d       = idx_q;
		npop_d      = npop_q;
		cmd_d       = cmd_q;
		res_d       = res_q;
		res_valid_d = res_valid_q;
		after_d     = after_q;
		popped_d    = popped_q;
		rd_addr     = idx_q[AW-1:0];
		wr_en       = 1'b0;
		wr_addr     = idx_q[AW-1:0];
		wr_data     = '{expiry: cmd_q.expire_time, handle: cmd_q.handle};

		unique case (state_q)
			setq_pkg::S_IDLE: begin
				if (in_ch.valid) begin
					cmd_d  = in_ch.data;
					idx_d  = '0;
					npop_d = '0;
					if (setq_pkg::cmd_t'(in_ch.data.cmd) == setq_pkg::CMD_TICK)
						state_d = setq_pkg::S_TICK_RD;
					else if (setq_pkg::cmd_t'(in_ch.data.cmd) == setq_pkg::CMD_ADD &&
							count_q == CW'(ENTRIES)) begin
						res_d       = mk_res('0, 1'b0, setq_pkg::ST_FULL, 1'b1);
						res_valid_d = 1'b1;
						after_d     = setq_pkg::S_IDLE;
						state_d     = setq_pkg::S_EMIT;
					end else
						state_d = setq_pkg::S_FIND_RD;
				end
			end
			// scan for the handle, one entry per S_FIND_RD/S_FIND_CHK pair
			setq_pkg::S_FIND_RD: begin
				if (idx_q >= count_q) begin
					if (setq_pkg::cmd_t'(cmd_q.cmd) == setq_pkg::CMD_ADD) begin
						idx_d   = count_q;
						state_d = setq_pkg::S_INS_RD;
					end else begin
						res_d       = mk_res('0, 1'b0, setq_pkg::ST_NOT_FOUND, 1'b1);
						res_valid_d = 1'b1;
						after_d     = setq_pkg::S_IDLE;
						state_d     = setq_pkg::S_EMIT;
					end
				end else
					state_d = setq_pkg::S_FIND_CHK;
			end
			setq_pkg::S_FIND_CHK: begin
				if (rd_data_q.handle == cmd_q.handle) begin
					if (setq_pkg::cmd_t'(cmd_q.cmd) == setq_pkg::CMD_ADD) begin
						res_d       = mk_res('0, 1'b0, setq_pkg::ST_DUP, 1'b1);
						res_valid_d = 1'b1;
						after_d     = setq_pkg::S_IDLE;
						state_d     = setq_pkg::S_EMIT;
					end else
						state_d = setq_pkg::S_REM_RD;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = setq_pkg::S_FIND_RD;
				end
			end
			// shift entries above idx down by one
			setq_pkg::S_REM_RD: begin
				if (idx_q + 1'b1 >= count_q) begin
					count_d = count_q - 1'b1;
					if (setq_pkg::cmd_t'(cmd_q.cmd) == setq_pkg::CMD_ADJUST) begin
						idx_d   = count_q - 1'b1;
						state_d = setq_pkg::S_INS_RD;
					end else if (setq_pkg::cmd_t'(cmd_q.cmd) == setq_pkg::CMD_TICK) begin
						npop_d   = npop_q + 1'b1;
						res_d    = mk_res(popped_q.handle, 1'b1, setq_pkg::ST_OK, 1'b0);
						after_d  = setq_pkg::S_TICK_RD;
						idx_d    = '0;
						// last flag settled once next pop is checked
						state_d  = setq_pkg::S_TICK_RD;
					end else begin
						res_d       = mk_res('0, 1'b0, setq_pkg::ST_OK, 1'b1);
						res_valid_d = 1'b1;
						after_d     = setq_pkg::S_IDLE;
						state_d     = setq_pkg::S_EMIT;
					end
				end else begin
					rd_addr = AW'(idx_q + 1'b1);
					state_d = setq_pkg::S_REM_WR;
				end
			end
			setq_pkg::S_REM_WR: begin
				wr_en   = 1'b1;
				wr_data = rd_data_q;
				idx_d   = idx_q + 1'b1;
				state_d = setq_pkg::S_REM_RD;
			end
			// insertion: idx is the free slot; move larger entries up
			setq_pkg::S_INS_RD: begin
				if (idx_q == '0) begin
					wr_en       = 1'b1;
					count_d     = count_q + 1'b1;
					res_d       = mk_res('0, 1'b0, setq_pkg::ST_OK, 1'b1);
					res_valid_d = 1'b1;
					after_d     = setq_pkg::S_IDLE;
					state_d     = setq_pkg::S_EMIT;
				end else begin
					rd_addr = AW'(idx_q - 1'b1);
					state_d = setq_pkg::S_INS_CHK;
				end
			end
			setq_pkg::S_INS_CHK: begin
				if (rd_data_q.expiry > cmd_q.expire_time) begin
					wr_en   = 1'b1;
					wr_data = rd_data_q;
					idx_d   = idx_q - 1'b1;
					state_d = setq_pkg::S_INS_RD;
				end else begin
					wr_en       = 1'b1;
					count_d     = count_q + 1'b1;
					res_d       = mk_res('0, 1'b0, setq_pkg::ST_OK, 1'b1);
					res_valid_d = 1'b1;
					after_d     = setq_pkg::S_IDLE;
					state_d     = setq_pkg::S_EMIT;
				end
			end
			setq_pkg::S_INS_WR: state_d = setq_pkg::S_IDLE;
			// tick: examine head; a pending pop result is held in res_q
			setq_pkg::S_TICK_RD: begin
				rd_addr = '0;
				state_d = setq_pkg::S_TICK_CHK;
			end
			setq_pkg::S_TICK_CHK: begin
				if (npop_q != RW'(setq_pkg::MaxResults) && count_q != '0 &&
						rd_data_q.expiry <= cmd_q.now) begin
					popped_d = rd_data_q;
					idx_d    = '0;
					if (npop_q != '0) begin
						res_valid_d = 1'b1;
						after_d     = setq_pkg::S_REM_RD;
						state_d     = setq_pkg::S_EMIT;
					end else
						state_d = setq_pkg::S_REM_RD;
				end else begin
					if (npop_q == '0)
						res_d = mk_res('0, 1'b0, setq_pkg::ST_OK, 1'b1);
					else
						res_d.last = 1'b1;
					res_valid_d = 1'b1;
					after_d     = setq_pkg::S_IDLE;
					state_d     = setq_pkg::S_EMIT;
				end
			end
			setq_pkg::S_EMIT: begin
				if (out_ch.ready) begin
					res_valid_d = 1'b0;
					state_d     = after_q;
				end
			end
			default: state_d = setq_pkg::S_IDLE;
		endcase
	end

	// occupancy never exceeds capacity
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES)) else $error("count overflow");
	// a result stays up only while emitting
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> state_q == setq_pkg::S_EMIT) else $error("stray result");
	// no new command while a result is pending
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !in_ch.ready) else $error("accept while busy");
	// count moves by at most one per cycle
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> (count_q == $past(count_q) + 1'b1 ||
		count_q == $past(count_q) - 1'b1)) else $error("count jump");
endmodule
`default_nettype wire
